/* design/srp_pkg.sv */
// shared types and constants for the serial reply parser
// no dependencies; used by every module of the block

package srp_pkg;

   // frame selector and terminator characters
   localparam logic [7:0] CH_ACK   = 8'h61;  // 'a'
   localparam logic [7:0] CH_RETX  = 8'h74;  // 't'
   localparam logic [7:0] CH_RESP  = 8'h72;  // 'r'
   localparam logic [7:0] CH_ABORT = 8'h41;  // 'A'
   localparam logic [7:0] CH_RETOK = 8'h78;  // 'x'
   localparam logic [7:0] CH_CLEAR = 8'h43;  // 'C'

   // parse modes, one-hot
   typedef enum logic [6:0] {
      PM_IDLE  = 7'b0000001,
      PM_ACK   = 7'b0000010,
      PM_RETX  = 7'b0000100,
      PM_RID   = 7'b0001000,
      PM_RLEN  = 7'b0010000,
      PM_RDATA = 7'b0100000,
      PM_ABORT = 7'b1000000
   } mode_type;

   typedef enum logic [2:0] {
      EV_ACK     = 3'd0,
      EV_RETX    = 3'd1,
      EV_BADRETX = 3'd2,
      EV_RBYTE   = 3'd3,
      EV_EMPTY   = 3'd4,
      EV_ABORT   = 3'd5,
      EV_CLEAR   = 3'd6,
      EV_UNEXP   = 3'd7
   } event_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_word_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] cmd_id;
      logic [7:0] data_byte;
      logic [7:0] data_index;
      logic [7:0] reply_length;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic emit;
      logic advance;
   } step_ctrl_type;

endpackage

/* design/srp_if.sv */
// handshake channel interfaces for the serial reply parser
// depends on nothing but plain logic types

interface srp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface srp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] cmd_id;
   logic [7:0] data_byte;
   logic [7:0] data_index;
   logic [7:0] reply_length;
   logic       last;

   modport source (
      output valid, output event_res, output cmd_id, output data_byte,
      output data_index, output reply_length, output last, input ready
   );
   modport sink (
      input valid, input event_res, input cmd_id, input data_byte,
      input data_index, input reply_length, input last, output ready
   );
endinterface

/* design/srp_in_stage.sv */
// input register of the serial reply parser: holds one received word
// depends on srp_pkg

module srp_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_byte,
   input  logic                advance,
   output logic                req_ready,
   output srp_pkg::in_word_type in_word
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   // a new word may enter when the held one leaves in the same cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_word = '{valid: valid_ff, rx_byte: byte_ff};

endmodule

/* design/srp_decode.sv */
// frame decoder of the serial reply parser: parse mode, response context
// and the result of the held word; depends on srp_pkg

module srp_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  srp_pkg::in_word_type in_word,
   input  logic                 advance,
   output logic                 emit,
   output srp_pkg::rsp_word_type result
);

   srp_pkg::mode_type mode_ff, mode_in;
   logic [7:0] reply_id_ff, reply_id_in;
   logic [7:0] reply_len_ff, reply_len_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] b;
   logic [8:0] next_count;
   logic       final_byte;

   assign b          = in_word.rx_byte;
   assign next_count = {1'b0, seen_ff} + 9'd1;
   assign final_byte = next_count >= {1'b0, reply_len_ff};

   always_comb begin
      mode_in      = mode_ff;
      reply_id_in  = reply_id_ff;
      reply_len_in = reply_len_ff;
      seen_in      = seen_ff;
      emit         = 1'b0;
      result       = '0;
      unique case (mode_ff)
         srp_pkg::PM_ACK: begin
            mode_in          = srp_pkg::PM_IDLE;
            emit             = 1'b1;
            result.event_res = srp_pkg::EV_ACK;
            result.cmd_id    = b;
         end
         srp_pkg::PM_RETX: begin
            mode_in          = srp_pkg::PM_IDLE;
            emit             = 1'b1;
            result.event_res = (b == srp_pkg::CH_RETOK) ? srp_pkg::EV_RETX
                                                        : srp_pkg::EV_BADRETX;
         end
         srp_pkg::PM_RID: begin
            reply_id_in = b;
            mode_in     = srp_pkg::PM_RLEN;
         end
         srp_pkg::PM_RLEN: begin
            reply_len_in = b;
            seen_in      = '0;
            if (b == 8'd0) begin
               mode_in          = srp_pkg::PM_IDLE;
               emit             = 1'b1;
               result.event_res = srp_pkg::EV_EMPTY;
               result.cmd_id    = reply_id_ff;
            end else begin
               mode_in = srp_pkg::PM_RDATA;
            end
         end
         srp_pkg::PM_RDATA: begin
            seen_in             = next_count[7:0];
            emit                = 1'b1;
            result.event_res    = srp_pkg::EV_RBYTE;
            result.cmd_id       = reply_id_ff;
            result.data_byte    = b;
            result.data_index   = seen_ff;
            result.reply_length = reply_len_ff;
            result.last         = final_byte;
            if (final_byte) begin
               mode_in = srp_pkg::PM_IDLE;
            end
         end
         srp_pkg::PM_ABORT: begin
            if (b == srp_pkg::CH_CLEAR) begin
               mode_in          = srp_pkg::PM_IDLE;
               emit             = 1'b1;
               result.event_res = srp_pkg::EV_CLEAR;
            end
         end
         default: begin
            // idle: the word selects the frame kind
            priority if (b == srp_pkg::CH_ACK) begin
               mode_in = srp_pkg::PM_ACK;
            end else if (b == srp_pkg::CH_RETX) begin
               mode_in = srp_pkg::PM_RETX;
            end else if (b == srp_pkg::CH_RESP) begin
               mode_in = srp_pkg::PM_RID;
            end else if (b == srp_pkg::CH_ABORT) begin
               mode_in          = srp_pkg::PM_ABORT;
               emit             = 1'b1;
               result.event_res = srp_pkg::EV_ABORT;
            end else begin
               mode_in          = srp_pkg::PM_IDLE;
               emit             = 1'b1;
               result.event_res = srp_pkg::EV_UNEXP;
            end
         end
      endcase
      if (!in_word.valid) begin
         emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= srp_pkg::PM_IDLE;
         reply_id_ff  <= '0;
         reply_len_ff <= '0;
         seen_ff      <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         reply_id_ff  <= reply_id_in;
         reply_len_ff <= reply_len_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

/* design/srp_out_stage.sv */
// result register of the serial reply parser
// depends on srp_pkg

module srp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  srp_pkg::step_ctrl_type ctrl,
   input  srp_pkg::rsp_word_type result,
   input  logic                  rsp_ready,
   output logic                  can_load,
   output logic                  rsp_valid,
   output srp_pkg::rsp_word_type rsp_word
);

   logic                  valid_ff, valid_in;
   srp_pkg::rsp_word_type word_ff, word_in;
   logic                  load;

   assign can_load = !valid_ff || rsp_ready;
   assign load     = ctrl.advance && ctrl.emit;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

/* design/serial_reply_parser_unit.sv */
// serial reply parser, top level: input register, frame decoder, result register
// depends on srp_pkg, srp_if, srp_in_stage, srp_decode, srp_out_stage
//
// req_chan takes one received byte per word. rsp_chan gives at most one
// event word per received byte: event code, command id, data byte, data
// index, announced length and last mark. Selector bytes a, t, r, the response
// id, a nonzero length byte and non-C bytes after an abort give no word.
// A byte accepted into the input register is decoded there, and its event
// word is loaded into the result register, which drives rsp_chan.
// A new byte is accepted every cycle and the rate is one word per cycle,
// as long as the receiver on rsp_chan does not stall.
// When the receiver stalls, the result register holds its word; the held
// input byte then waits only if it would produce a word, and req_chan.ready
// falls until the result register frees up.
// Reset (synchronous) returns the parser to idle, clears the response id,
// length and byte count, and empties both registers.

module serial_reply_parser_unit (
   input logic       clock,
   input logic       reset,
   srp_req_if.sink   req_chan,
   srp_rsp_if.source rsp_chan
);

   srp_pkg::in_word_type   in_word;
   srp_pkg::rsp_word_type  result;
   srp_pkg::rsp_word_type  rsp_word;
   srp_pkg::step_ctrl_type ctrl;
   logic                   emit;
   logic                   can_load;
   logic                   rsp_valid;

   // the held word moves on unless its event has nowhere to go
   assign ctrl = '{emit: emit, advance: in_word.valid && (!emit || can_load)};

   srp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.rx_byte),
      .advance   (ctrl.advance),
      .req_ready (req_chan.ready),
      .in_word   (in_word)
   );

   srp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_word (in_word),
      .advance (ctrl.advance),
      .emit    (emit),
      .result  (result)
   );

   srp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .result    (result),
      .rsp_ready (rsp_chan.ready),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.event_res    = rsp_word.event_res;
   assign rsp_chan.cmd_id       = rsp_word.cmd_id;
   assign rsp_chan.data_byte    = rsp_word.data_byte;
   assign rsp_chan.data_index   = rsp_word.data_index;
   assign rsp_chan.reply_length = rsp_word.reply_length;
   assign rsp_chan.last         = rsp_word.last;

   // a held byte that is not consumed stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_word.valid && !ctrl.advance |=> in_word.valid && $stable(in_word.rx_byte))
      else $error("held input word lost or changed");

   // an event is never loaded over an undelivered word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance && ctrl.emit |-> !rsp_valid || rsp_chan.ready)
      else $error("result register overwritten");

   // last mark only on response data
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |-> rsp_word.event_res == srp_pkg::EV_RBYTE)
      else $error("last mark on a non-data event");

   // data index stays inside the announced length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_res == srp_pkg::EV_RBYTE
         |-> rsp_word.data_index < rsp_word.reply_length)
      else $error("data index beyond announced length");

endmodule
